// File: rtl/core/ginv_pkg.sv
// ----------------------------------------------------------------------------
// ginv_pkg
// Shared constants and types for the Goldilocks field inverse core.
// ----------------------------------------------------------------------------
package ginv_pkg;

	localparam int unsigned WORD_W = 64;
	localparam logic [WORD_W-1:0] FIELD_MODULUS = 64'hFFFF_FFFF_0000_0001;

	// Working set of the binary extended GCD
	typedef struct packed {
		logic [WORD_W-1:0] u;
		logic [WORD_W-1:0] v;
		logic [WORD_W-1:0] x1;
		logic [WORD_W-1:0] x2;
	} gcd_regs_t;

endpackage

// File: rtl/core/ginv_step.sv
// ----------------------------------------------------------------------------
// ginv_step
// One step of the binary extended GCD: halve an even remainder, or subtract
// the smaller remainder from the larger one, keeping coefficients mod p.
// ----------------------------------------------------------------------------
module ginv_step #(
	parameter logic [ginv_pkg::WORD_W-1:0] MODULUS = ginv_pkg::FIELD_MODULUS
) (
	input  ginv_pkg::gcd_regs_t cur,
	output ginv_pkg::gcd_regs_t nxt
);

	logic [ginv_pkg::WORD_W:0]   half_sum;
	logic [ginv_pkg::WORD_W-1:0] half_src;
	logic [ginv_pkg::WORD_W-1:0] half_res;
	logic [ginv_pkg::WORD_W-1:0] sub_a;
	logic [ginv_pkg::WORD_W-1:0] sub_b;
	logic [ginv_pkg::WORD_W-1:0] sub_res;
	logic                        u_ge_v;

	// Coefficient halving mod p
	always_comb begin
		half_src = cur.u[0] ? cur.x2 : cur.x1;
		if (half_src[0]) begin
			half_sum = {1'b0, half_src} + {1'b0, MODULUS};
		end else begin
			half_sum = {1'b0, half_src};
		end
		half_res = half_sum[ginv_pkg::WORD_W:1];
	end

	// Coefficient subtraction mod p
	assign u_ge_v = cur.u >= cur.v;
	always_comb begin
		sub_a = u_ge_v ? cur.x1 : cur.x2;
		sub_b = u_ge_v ? cur.x2 : cur.x1;
		if (sub_a >= sub_b) begin
			sub_res = sub_a - sub_b;
		end else begin
			sub_res = sub_a - sub_b + MODULUS;
		end
	end

	// Pick the step
	always_comb begin
		nxt = cur;
		if (!cur.u[0]) begin
			nxt.u  = cur.u >> 1;
			nxt.x1 = half_res;
		end else if (!cur.v[0]) begin
			nxt.v  = cur.v >> 1;
			nxt.x2 = half_res;
		end else if (u_ge_v) begin
			nxt.u  = cur.u - cur.v;
			nxt.x1 = sub_res;
		end else begin
			nxt.v  = cur.v - cur.u;
			nxt.x2 = sub_res;
		end
	end

endmodule

// File: rtl/core/goldilocks_field_inverse_core.sv
// ----------------------------------------------------------------------------
// goldilocks_field_inverse_core
// Inverse modulo p = 2^64 - 2^32 + 1 by binary extended GCD.
// ----------------------------------------------------------------------------
// One item is taken, reduced mod p, and inverted by a single shared step unit
// that halves or subtracts once per clock. How many steps an item takes
// depends on its value (up to one halving per bit of the two remainders
// together, each subtraction followed by a halving); a zero operand takes no
// steps and finishes with zero_error set. The block accepts no new item
// while one is in work. A finished result sits in an output register, so
// the next item is accepted while it waits.
module goldilocks_field_inverse_core #(
	parameter logic [63:0] MODULUS = ginv_pkg::FIELD_MODULUS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [63:0] inverse, [64] zero_error, rest zero
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                state_q;
	logic                zero_q;
	ginv_pkg::gcd_regs_t regs_q;
	ginv_pkg::gcd_regs_t regs_nxt;
	logic [63:0]         red_val;
	logic                done;
	logic                out_free;
	logic                out_valid_q;
	logic [63:0]         inv_q;
	logic                err_q;

	ginv_step #(
		.MODULUS (MODULUS)
	) u_step (
		.cur (regs_q),
		.nxt (regs_nxt)
	);

	// Input reduction: one subtract suffices
	assign red_val  = (s_tdata >= MODULUS) ? s_tdata - MODULUS : s_tdata;
	assign s_tready = (state_q == ST_IDLE);
	assign done     = zero_q || regs_q.u == 64'd1 || regs_q.v == 64'd1;
	assign out_free = !out_valid_q || m_tready;

	// Sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_RUN;
				ST_RUN:  if (done && out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			zero_q    <= (red_val == 64'd0);
			regs_q.u  <= red_val;
			regs_q.v  <= MODULUS;
			regs_q.x1 <= 64'd1;
			regs_q.x2 <= 64'd0;
		end else if (state_q == ST_RUN && !done) begin
			regs_q <= regs_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RUN && done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && done && out_free) begin
			err_q <= zero_q;
			if (zero_q) begin
				inv_q <= 64'd0;
			end else if (regs_q.u == 64'd1) begin
				inv_q <= regs_q.x1;
			end else begin
				inv_q <= regs_q.x2;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, err_q, inv_q};

	// Checks
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !s_tready)
		else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[64]) |-> (m_tdata[63:0] == 64'd0))
		else $error("error result not zero");
	a_inv_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:0] < MODULUS))
		else $error("inverse out of range");

endmodule

// File: test/goldilocks_field_inverse_checker.sv
// ----------------------------------------------------------------------------
// goldilocks_field_inverse_checker
// Watches both streams, predicts each inverse mod p and compares results.
// ----------------------------------------------------------------------------
// Every item accepted at the input is inverted here by an independent
// extended Euclid over 128-bit arithmetic and queued; every result accepted
// at the output is compared field by field against the oldest prediction.
module goldilocks_field_inverse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	output int          errors,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] inverse;
		logic        zero_error;
	} inv_result_t;

	inv_result_t expected_inverses[$];

	// Extended Euclid; coefficient kept mod p
	function automatic inv_result_t predict_inverse(logic [63:0] value);
		logic [127:0] p, r, nr, t, nt, q, prod, tmp;
		inv_result_t res;
		p = {64'd0, ginv_pkg::FIELD_MODULUS};
		r = p;
		nr = {64'd0, value};
		if (nr >= p) nr = nr - p;
		res.inverse = '0;
		res.zero_error = 1'b0;
		if (nr == 0) begin
			res.zero_error = 1'b1;
			return res;
		end
		t = 0;
		nt = 1;
		while (nr != 0) begin
			q = r / nr;
			prod = (q * nt) % p;
			tmp = (t >= prod) ? t - prod : t + p - prod;
			t = nt;
			nt = tmp;
			tmp = r % nr;
			r = nr;
			nr = tmp;
		end
		res.inverse = t[63:0];
		return res;
	endfunction

	assign pending = expected_inverses.size();

	always @(posedge clk or negedge arst_n) begin
		inv_result_t want, got;
		if (!arst_n) begin
			errors <= 0;
			results_seen <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_inverses.push_back(predict_inverse(s_tdata));
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				got.inverse = m_tdata[63:0];
				got.zero_error = m_tdata[64];
				if (expected_inverses.size() == 0) begin
					if (errors < 10)
						$display("unexpected result %h/%b", got.inverse, got.zero_error);
					errors <= errors + 1;
				end else begin
					want = expected_inverses.pop_front();
					if (want != got || m_tdata[71:65] != 0) begin
						if (errors < 10)
							$display("mismatch: expected inv %h err %b, got %h",
								want.inverse, want.zero_error, m_tdata);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// File: test/goldilocks_field_inverse_core_tb.sv
// ----------------------------------------------------------------------------
// goldilocks_field_inverse_core_tb
// Stimulus and verdict for the Goldilocks field inverse core.
// ----------------------------------------------------------------------------
// Directed edge operands, then random operands with random gaps and output
// stalls, a long output hold-off and a full drain pause.
module goldilocks_field_inverse_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1330;
	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	int          errors, pending, results_seen;
	int          idle_cycles = 0;
	int          items_sent = 0;
	bit          hold_output = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	goldilocks_field_inverse_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	goldilocks_field_inverse_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	// Send one operand, after a random gap if gaps is set; valid stays up across a zero gap
	task automatic send_operand(logic [63:0] value, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Drop valid and wait until every expected result has come
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = ginv_pkg::FIELD_MODULUS - $urandom_range(0, 3);
			1: v = ginv_pkg::FIELD_MODULUS + $urandom_range(0, 3);
			2: v = $urandom_range(0, 3);
			3: v = ~64'd0 - $urandom_range(0, 3);
			4: v = v >> $urandom_range(1, 63);
			default: ;
		endcase
		return v;
	endfunction

	// Output side: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_output = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready) && !hold_output);
		end
	end

	// Watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [63:0] directed[$];
		directed = '{64'd0, 64'd1, 64'd2, 64'd3, ginv_pkg::FIELD_MODULUS,
			ginv_pkg::FIELD_MODULUS - 1, ginv_pkg::FIELD_MODULUS - 2,
			ginv_pkg::FIELD_MODULUS + 1, ginv_pkg::FIELD_MODULUS + 2, ~64'd0,
			~64'd0 - 1, 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
			64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h7FFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_0000_0000, 64'h1234_5678_9ABC_DEF0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_operand(directed[i], 1'b0);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 100)
				hold_output = 1'b1;
			if (i == 400)
				drain_results();
			send_operand(random_operand(), i < 600 || i > 900);
		end
		drain_results();
		repeat (300) @(posedge clk);
		$display("Sent %0d operands, checked %0d inverses incl. zero and p-boundary cases.",
			items_sent, results_seen);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// File: files.f
rtl/core/ginv_pkg.sv
rtl/core/ginv_step.sv
rtl/core/goldilocks_field_inverse_core.sv
test/goldilocks_field_inverse_checker.sv
test/goldilocks_field_inverse_core_tb.sv
